/* hw/rtl/rbpl_pkg.sv */
// Shared types and constants for the ring buffer positional list.
package rbpl_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_DATA_WIDTH = 16;
    localparam int KIND_W         = 3;
    localparam int POS_W          = 4;
    localparam int STATUS_W       = 2;
    localparam int COUNT_W        = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 3'd0,
        KIND_POP    = 3'd1,
        KIND_INSERT = 3'd2,
        KIND_DELETE = 3'd3,
        KIND_READ   = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_BAD_POS = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_EXEC = 2'b10
    } fsm_t;

    // Broadcast to every cell for one execute cycle.
    typedef struct packed {
        logic shift_en;
        logic load_en;
    } cell_cmd_t;

endpackage

/* hw/rtl/ring_buffer_positional_list_core.sv */
// Top level: command capture, pointer control and the row of slot cells.
// done is registered from the execute state: the accepting edge sets state_reg to EXEC, and done_reg follows it.
// A new item is taken only in the idle state, never while busy; busy is high for the execute cycle.
// Every shift of insert or delete is done by the cells in parallel within the execute state.
// Reset (rst_n low, asynchronous): list empty, no result pending; slot contents undefined.
// Results are shown for one cycle with done; the receiver cannot stall.
module ring_buffer_positional_list_core
    import rbpl_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [KIND_W-1:0]     kind,
    input  logic [POS_W-1:0]      position,
    input  logic [DATA_WIDTH-1:0] value,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] read_data,
    output logic [STATUS_W-1:0]   status,
    output logic [COUNT_W-1:0]    count
);

    localparam int PTR_W = $clog2(ENTRIES);
    localparam int WIDE_W = PTR_W + POS_W;
    localparam logic [PTR_W-1:0]  ENT_P   = PTR_W'(ENTRIES);
    localparam logic [PTR_W-1:0]  LAST_P  = PTR_W'(ENTRIES - 1);
    localparam logic [WIDE_W-1:0] ENT_W   = WIDE_W'(ENTRIES);

    fsm_t                  state_reg, state_next;
    logic [PTR_W-1:0]      front_reg, front_next;
    logic [PTR_W-1:0]      rear_reg, rear_next;
    logic [KIND_W-1:0]     kind_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic                  done_reg;
    logic [DATA_WIDTH-1:0] rdata_reg, rdata_next;
    logic [STATUS_W-1:0]   status_reg;
    status_t               status_next;
    logic [COUNT_W-1:0]    count_reg;

    logic                  accept;
    logic                  exec;
    logic [PTR_W-1:0]      n;
    logic [PTR_W-1:0]      n_new;
    logic [PTR_W-1:0]      rear_inc;
    logic [PTR_W-1:0]      front_inc;
    logic [PTR_W-1:0]      front_dec;
    logic [PTR_W-1:0]      rear_dec;
    logic                  empty;
    logic                  full;
    logic                  bad_k;
    logic [WIDE_W-1:0]     k_w;
    logic [WIDE_W-1:0]     n_w;
    logic [WIDE_W-1:0]     rd_sum;
    logic [WIDE_W-1:0]     rd_slot_w;
    logic [PTR_W-1:0]      k_p;
    logic [WIDE_W-1:0]     n_new_w;

    logic                  sh_en;
    logic                  ld_en;
    cell_cmd_t             cell_cmd;
    logic [PTR_W-1:0]      shift_lo;
    logic [PTR_W-1:0]      shift_hi;
    logic [PTR_W-1:0]      load_off;

    logic [DATA_WIDTH-1:0] cell_data [ENTRIES];

    assign accept = start && (state_reg == FSM_IDLE);
    assign exec   = (state_reg == FSM_EXEC);
    assign busy   = exec;

    // pointer arithmetic
    assign n         = (rear_reg >= front_reg) ? (rear_reg - front_reg)
                                               : (rear_reg + (ENT_P - front_reg));
    assign rear_inc  = (rear_reg == LAST_P) ? '0 : rear_reg + 1'b1;
    assign front_inc = (front_reg == LAST_P) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_P : front_reg - 1'b1;
    assign rear_dec  = (rear_reg == '0) ? LAST_P : rear_reg - 1'b1;
    assign empty     = (front_reg == rear_reg);
    assign full      = (rear_inc == front_reg);

    assign k_w   = {{PTR_W{1'b0}}, pos_reg};
    assign n_w   = {{POS_W{1'b0}}, n};
    assign bad_k = (pos_reg == '0) || (k_w > n_w);
    assign k_p   = k_w[PTR_W-1:0];

    // slot of element k; only used when k is within the list
    assign rd_sum    = {{POS_W{1'b0}}, front_reg} + k_w;
    assign rd_slot_w = (rd_sum >= ENT_W) ? (rd_sum - ENT_W) : rd_sum;

    always_comb
    begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        status_next = STAT_OK;
        rdata_next  = '0;
        n_new       = n;
        sh_en       = 1'b0;
        ld_en       = 1'b0;
        shift_lo    = '0;
        shift_hi    = '0;
        load_off    = n + 1'b1;
        unique case (kind_reg)
            KIND_PUSH:
            begin
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    ld_en     = 1'b1;
                    rear_next = rear_inc;
                    n_new     = n + 1'b1;
                end
            end
            KIND_POP:
            begin
                if (empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    front_next = front_inc;
                    n_new      = n - 1'b1;
                end
            end
            KIND_INSERT:
            begin
                if (empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else if (bad_k)
                begin
                    status_next = STAT_BAD_POS;
                end
                else if (full)
                begin
                    status_next = STAT_FULL;
                end
                else if (k_p == n)
                begin
                    ld_en     = 1'b1;
                    rear_next = rear_inc;
                    n_new     = n + 1'b1;
                end
                else
                begin
                    // elements 1..k move down one slot, value lands at offset k
                    sh_en      = 1'b1;
                    ld_en      = 1'b1;
                    shift_lo   = '0;
                    shift_hi   = k_p;
                    load_off   = k_p;
                    front_next = front_dec;
                    n_new      = n + 1'b1;
                end
            end
            KIND_DELETE:
            begin
                if (empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else if (bad_k)
                begin
                    status_next = STAT_BAD_POS;
                end
                else if (k_p == PTR_W'(1))
                begin
                    front_next = front_inc;
                    n_new      = n - 1'b1;
                end
                else
                begin
                    // later elements move down one slot
                    sh_en     = 1'b1;
                    shift_lo  = k_p;
                    shift_hi  = n;
                    rear_next = rear_dec;
                    n_new     = n - 1'b1;
                end
            end
            KIND_READ:
            begin
                if (empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else if (bad_k)
                begin
                    status_next = STAT_BAD_POS;
                end
                else
                begin
                    rdata_next = cell_data[rd_slot_w[PTR_W-1:0]];
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    assign n_new_w = {{POS_W{1'b0}}, n_new};

    assign cell_cmd.shift_en = exec && sh_en;
    assign cell_cmd.load_en  = exec && ld_en;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            front_reg <= '0;
            rear_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            if (exec)
            begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            pos_reg   <= position;
            value_reg <= value;
        end
        if (exec)
        begin
            rdata_reg  <= rdata_next;
            status_reg <= status_next;
            count_reg  <= n_new_w[COUNT_W-1:0];
        end
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        localparam int NXT = (i + 1) % ENTRIES;
        rbpl_cell #(
            .ENTRIES    (ENTRIES),
            .DATA_WIDTH (DATA_WIDTH),
            .SLOT       (i)
        ) u_cell (
            .clk       (clk),
            .cmd       (cell_cmd),
            .front     (front_reg),
            .shift_lo  (shift_lo),
            .shift_hi  (shift_hi),
            .load_off  (load_off),
            .load_data (value_reg),
            .next_data (cell_data[NXT]),
            .data      (cell_data[i])
        );
    end

    assign done      = done_reg;
    assign read_data = rdata_reg;
    assign status    = status_reg;
    assign count     = count_reg;

    // assertions
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == FSM_EXEC))
        else $error("result strobe without an execute cycle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted item did not enter execute");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({{POS_W{1'b0}}, front_reg} < ENT_W) && ({{POS_W{1'b0}}, rear_reg} < ENT_W))
        else $error("ring pointer out of range");

    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        cell_cmd.load_en |-> (exec && (status_next == STAT_OK)))
        else $error("cell load on a failed operation");

endmodule

/* hw/rtl/rbpl_cell.sv */
// One ring slot: takes its upper neighbor's item on a shift, or the new value on a load.
module rbpl_cell
    import rbpl_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int SLOT       = 0,
    localparam int PTR_W     = $clog2(ENTRIES)
)
(
    input  logic                  clk,
    input  cell_cmd_t             cmd,
    input  logic [PTR_W-1:0]      front,
    input  logic [PTR_W-1:0]      shift_lo,
    input  logic [PTR_W-1:0]      shift_hi,
    input  logic [PTR_W-1:0]      load_off,
    input  logic [DATA_WIDTH-1:0] load_data,
    input  logic [DATA_WIDTH-1:0] next_data,
    output logic [DATA_WIDTH-1:0] data
);

    localparam logic [PTR_W-1:0] SLOT_P = PTR_W'(SLOT);
    localparam logic [PTR_W-1:0] ENT_P  = PTR_W'(ENTRIES);

    logic [PTR_W-1:0]      offset;
    logic [DATA_WIDTH-1:0] data_reg;

    // list offset of this slot; wraps correctly even when ENTRIES is a power of two
    always_comb
    begin
        if (SLOT_P >= front)
        begin
            offset = SLOT_P - front;
        end
        else
        begin
            offset = SLOT_P + (ENT_P - front);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_en && (offset == load_off))
        begin
            data_reg <= load_data;
        end
        else if (cmd.shift_en && (offset >= shift_lo) && (offset < shift_hi))
        begin
            data_reg <= next_data;
        end
    end

    assign data = data_reg;

endmodule
